// ----- rtl/core/lsp_pkg.sv -----
// ----------------------------------------------------------------------------
// lsp_pkg
// Shared types and fixed field widths of the looping sample player.
// ----------------------------------------------------------------------------
package lsp_pkg;

  // Fixed formats of the stream fields
  localparam int SAMPLE_BITS = 16;              // stored sample width
  localparam int FRAC_BITS   = 16;              // fraction bits of the position
  localparam int INT_W       = 32;              // integer part of the position
  localparam int POS_W       = INT_W + FRAC_BITS;
  localparam int LEN_W       = 17;              // range and loop lengths
  localparam int OFF_W       = 16;              // loop offset
  localparam int STEP_W      = 23;
  localparam int PITCH_W     = 16;
  localparam int GAIN_W      = 16;
  localparam int PITCH_SHIFT = 14;              // Q2.14 pitch factor
  localparam int GAIN_SHIFT  = 15;              // Q1.15 gain
  localparam int FUNC_W      = 2;
  localparam int CFG_IDX_W   = 3;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_WRITE = 2'd0,
    FUNC_START = 2'd1,
    FUNC_TICK  = 2'd2
  } func_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LOOP_EN   = 3'd0,
    CFG_REVERSED  = 3'd1,
    CFG_RANGE_LEN = 3'd2,
    CFG_LOOP_OFF  = 3'd3,
    CFG_LOOP_LEN  = 3'd4
  } cfg_idx_e;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_WRITE,
    ST_START,
    ST_TICK,
    ST_CHECK,
    ST_MOD,
    ST_IDX,
    ST_RD0,
    ST_RD1,
    ST_RD2,
    ST_IL,
    ST_IR,
    ST_GL,
    ST_GR,
    ST_RCAP,
    ST_STEPM,
    ST_POS,
    ST_FINISH
  } state_e;

endpackage

// ----- rtl/core/looping_sample_player.sv -----
// ----------------------------------------------------------------------------
// looping_sample_player
// Stereo sample player with looping, reverse play and linear interpolation.
// ----------------------------------------------------------------------------
// Each input transaction carries one command in s_axis_tuser: write a stereo
// sample into the store, start a note (load a Q16.16 position and step and
// arm the voice), or tick (render one interpolated, gain-scaled stereo frame
// and advance the position by step times the Q2.14 pitch factor). Every
// command returns exactly one output transaction. The block handles one
// command at a time and drops s_axis_tready while it works. A tick runs the
// serial remainder unit that maps the position into the loop (32 steps, one
// dividend bit per cycle), then two store reads and five passes through the
// single shared multiplier; a forward tick ahead of the loop offset skips the
// remainder, a zero-length loop skips all but the step product, and a
// one-shot end skips all of these.
// A finished result waits in the output register, and the next command is
// accepted meanwhile. The sample store is not cleared after reset: reading a
// location that was never written gives an undefined sample. SAMPLE_DEPTH
// must be a power of two; store addresses and sample indices wrap at it.
// Configuration writes take effect at once and belong in idle periods.
// ----------------------------------------------------------------------------
module looping_sample_player
  import lsp_pkg::*;
#(
  parameter int SAMPLE_DEPTH = 65536
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // configuration write port
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [LEN_W-1:0]     cfg_data_i,
  // command stream
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  // sample_addr[15:0], left_in[31:16], right_in[47:32], start_pos[79:48],
  // start_step[102:80], pitch_mod[118:103], gain[134:119], zero pad [135]
  input  logic [135:0]         s_axis_tdata,
  // func[1:0]
  input  logic [FUNC_W-1:0]    s_axis_tuser,
  // result stream
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  // left_out[15:0], right_out[31:16], voice_active[32], zero pad [39:33]
  output logic [39:0]          m_axis_tdata
);

  localparam int AW      = $clog2(SAMPLE_DEPTH);
  localparam int MA_W    = STEP_W + 1;          // signed multiplier operand A
  localparam int MB_W    = GAIN_W + 1;          // signed multiplier operand B
  localparam int MW      = MA_W + MB_W;         // product width
  localparam int IW      = INT_W + 2;           // signed index arithmetic
  localparam int RAM_W   = 2 * SAMPLE_BITS;

  localparam logic signed [MW:0] RND_F = (MW+1)'(1) <<< (FRAC_BITS - 1);
  localparam logic signed [MW:0] RND_G = (MW+1)'(1) <<< (GAIN_SHIFT - 1);
  localparam logic signed [MW:0] SMAX  = (MW+1)'((1 << (SAMPLE_BITS - 1)) - 1);
  localparam logic signed [MW:0] SMIN  = -SMAX - (MW+1)'(1);

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic             loop_en_q;
  logic             reversed_q;
  logic [LEN_W-1:0] range_len_q;
  logic [OFF_W-1:0] loop_off_q;
  logic [LEN_W-1:0] loop_len_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      loop_en_q   <= 1'b1;
      reversed_q  <= 1'b0;
      range_len_q <= '0;
      loop_off_q  <= '0;
      loop_len_q  <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_LOOP_EN:   loop_en_q   <= cfg_data_i[0];
        CFG_REVERSED:  reversed_q  <= cfg_data_i[0];
        CFG_RANGE_LEN: range_len_q <= cfg_data_i;
        CFG_LOOP_OFF:  loop_off_q  <= cfg_data_i[OFF_W-1:0];
        CFG_LOOP_LEN:  loop_len_q  <= cfg_data_i;
        default: ;  // writes outside the register list are dropped
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Command latch
  // --------------------------------------------------------------------------
  logic                          in_accept;
  logic [FUNC_W-1:0]             func_q;
  logic [15:0]                   addr_q;
  logic [SAMPLE_BITS-1:0]        left_in_q;
  logic [SAMPLE_BITS-1:0]        right_in_q;
  logic [INT_W-1:0]              spos_q;
  logic [STEP_W-1:0]             sstep_q;
  logic [PITCH_W-1:0]            pitch_q;
  logic [GAIN_W-1:0]             gain_q;

  assign in_accept = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      func_q     <= s_axis_tuser;
      addr_q     <= s_axis_tdata[15:0];
      left_in_q  <= s_axis_tdata[31:16];
      right_in_q <= s_axis_tdata[47:32];
      spos_q     <= s_axis_tdata[79:48];
      sstep_q    <= s_axis_tdata[102:80];
      pitch_q    <= s_axis_tdata[118:103];
      gain_q     <= s_axis_tdata[134:119];
    end
  end

  // --------------------------------------------------------------------------
  // Voice state
  // --------------------------------------------------------------------------
  state_e            state_q, state_d;
  logic [POS_W-1:0]  pos_q;
  logic [STEP_W-1:0] step_q;
  logic              active_q;

  logic [INT_W-1:0]     u_pos;
  logic [FRAC_BITS-1:0] frac;
  assign u_pos = pos_q[POS_W-1:FRAC_BITS];
  assign frac  = pos_q[FRAC_BITS-1:0];

  // Effective length: the loop cut to the range, or the whole range one-shot
  logic [LEN_W-1:0] off_ext;
  logic [LEN_W-1:0] span;
  logic [LEN_W-1:0] len_c;
  logic [LEN_W-1:0] len_q;

  assign off_ext = LEN_W'(loop_off_q);
  assign span    = range_len_q - off_ext;

  always_comb begin
    if (!loop_en_q) begin
      len_c = range_len_q;
    end else if (off_ext >= range_len_q) begin
      len_c = '0;
    end else if (loop_len_q < span) begin
      len_c = loop_len_q;
    end else begin
      len_c = span;
    end
  end

  // Tick decisions, made once the length is registered
  logic             one_shot_end;
  logic             fwd_direct_c;
  logic             fwd_direct_q;
  logic [INT_W-1:0] mod_dividend;

  assign one_shot_end = !loop_en_q &&
                        ((INT_W+1)'(u_pos) + (INT_W+1)'(2) > (INT_W+1)'(len_q));
  assign fwd_direct_c = !reversed_q && (u_pos < INT_W'(loop_off_q));
  assign mod_dividend = reversed_q ? u_pos : (u_pos - INT_W'(loop_off_q));

  // --------------------------------------------------------------------------
  // Serial remainder by the effective length
  // --------------------------------------------------------------------------
  logic             mod_start;
  logic             mod_done;
  logic [LEN_W-1:0] mod_rem;

  lsp_mod_unit u_mod (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (mod_start),
    .dividend_i (mod_dividend),
    .divisor_i  (len_q),
    .done_o     (mod_done),
    .rem_o      (mod_rem)
  );

  // --------------------------------------------------------------------------
  // Index mapping for the sample and its neighbor
  // --------------------------------------------------------------------------
  logic signed [IW-1:0] u0_s, u1_s, m0_s, m1_s, last_s, off_s;
  logic signed [IW-1:0] r0, r1;
  logic [LEN_W:0]       m_inc;
  logic [AW-1:0]        idx0_q, idx1_q;

  always_comb begin
    m_inc  = (LEN_W+1)'(mod_rem) + (LEN_W+1)'(1);
    u0_s   = IW'(u_pos);
    u1_s   = u0_s + IW'(1);
    m0_s   = IW'(mod_rem);
    m1_s   = (m_inc == (LEN_W+1)'(len_q)) ? '0 : IW'(m_inc);
    last_s = IW'(range_len_q) - IW'(1);
    off_s  = IW'(loop_off_q);
    if (reversed_q) begin
      r0 = (u0_s > IW'(len_q)) ? (last_s - m0_s) : (last_s - u0_s);
      r1 = (u1_s > IW'(len_q)) ? (last_s - m1_s) : (last_s - u1_s);
      // clamp reads before the range start
      if (r0 < 0) begin
        r0 = '0;
      end
      if (r1 < 0) begin
        r1 = '0;
      end
    end else if (fwd_direct_q) begin
      r0 = u0_s;
      r1 = u1_s;
    end else begin
      r0 = m0_s + off_s;
      r1 = m1_s + off_s;
    end
  end

  // --------------------------------------------------------------------------
  // Sample store
  // --------------------------------------------------------------------------
  logic              ram_we;
  logic              ram_re;
  logic [AW-1:0]     ram_raddr;
  logic [AW-1:0]     ram_waddr;
  logic [AW+15:0]    addr_ext;
  logic [RAM_W-1:0]  ram_rdata;

  assign addr_ext  = {{AW{1'b0}}, addr_q};
  assign ram_waddr = addr_ext[AW-1:0];

  lsp_ram #(
    .WIDTH (RAM_W),
    .DEPTH (SAMPLE_DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i ({right_in_q, left_in_q}),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // --------------------------------------------------------------------------
  // Shared multiplier: interpolation, gain and position step in turn
  // --------------------------------------------------------------------------
  logic signed [SAMPLE_BITS-1:0] al_q, ar_q, bl_q, br_q;
  logic signed [SAMPLE_BITS-1:0] sl_q, sr_q;
  logic signed [SAMPLE_BITS:0]   diff_l, diff_r;
  logic signed [MA_W-1:0]        mul_a;
  logic signed [MB_W-1:0]        mul_b;
  logic signed [MW-1:0]          prod_q;

  assign diff_l = {bl_q[SAMPLE_BITS-1], bl_q} - {al_q[SAMPLE_BITS-1], al_q};
  assign diff_r = {br_q[SAMPLE_BITS-1], br_q} - {ar_q[SAMPLE_BITS-1], ar_q};

  always_ff @(posedge clk_i) begin
    prod_q <= mul_a * mul_b;
  end

  // Interpolation: prev * 2^F + product, rounded half up
  logic signed [SAMPLE_BITS-1:0] interp_base;
  logic signed [MW:0]            interp_acc;
  logic signed [SAMPLE_BITS-1:0] interp_val;

  assign interp_base = (state_q == ST_IR) ? al_q : ar_q;
  assign interp_acc  = {{(MW+1-SAMPLE_BITS-FRAC_BITS){interp_base[SAMPLE_BITS-1]}},
                        interp_base, {FRAC_BITS{1'b0}}}
                       + {prod_q[MW-1], prod_q} + RND_F;
  assign interp_val  = interp_acc[FRAC_BITS+SAMPLE_BITS-1:FRAC_BITS];

  // Gain: round, floor shift and saturate
  logic signed [MW:0]            gain_acc;
  logic signed [MW:0]            gain_y;
  logic signed [SAMPLE_BITS-1:0] gain_sat;

  always_comb begin
    gain_acc = {prod_q[MW-1], prod_q} + RND_G;
    gain_y   = gain_acc >>> GAIN_SHIFT;
    if (gain_y > SMAX) begin
      gain_sat = SMAX[SAMPLE_BITS-1:0];
    end else if (gain_y < SMIN) begin
      gain_sat = SMIN[SAMPLE_BITS-1:0];
    end else begin
      gain_sat = gain_y[SAMPLE_BITS-1:0];
    end
  end

  logic [POS_W-1:0] pos_adv;
  assign pos_adv = pos_q + POS_W'(prod_q[STEP_W+PITCH_W-1:PITCH_SHIFT]);

  // --------------------------------------------------------------------------
  // Output register
  // --------------------------------------------------------------------------
  logic                          out_valid_q;
  logic                          out_free;
  logic signed [SAMPLE_BITS-1:0] res_l_q, res_r_q;
  logic signed [SAMPLE_BITS-1:0] out_l_q, out_r_q;
  logic                          out_act_q;

  assign out_free = !out_valid_q || m_axis_tready;

  // --------------------------------------------------------------------------
  // Sequencer
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d   = state_q;
    ram_we    = 1'b0;
    ram_re    = 1'b0;
    ram_raddr = idx0_q;
    mod_start = 1'b0;
    mul_a     = '0;
    mul_b     = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (s_axis_tvalid) begin
          case (s_axis_tuser)
            FUNC_WRITE: state_d = ST_WRITE;
            FUNC_START: state_d = ST_START;
            FUNC_TICK:  state_d = active_q ? ST_TICK : ST_FINISH;
            default:    state_d = ST_FINISH;  // unused command: no effect
          endcase
        end
      end
      ST_WRITE: begin
        ram_we  = 1'b1;
        state_d = ST_FINISH;
      end
      ST_START: state_d = ST_FINISH;
      ST_TICK:  state_d = ST_CHECK;
      ST_CHECK: begin
        if (one_shot_end) begin
          state_d = ST_FINISH;
        end else if (len_q == '0) begin
          state_d = ST_STEPM;
        end else if (fwd_direct_c) begin
          state_d = ST_IDX;
        end else begin
          mod_start = 1'b1;
          state_d   = ST_MOD;
        end
      end
      ST_MOD: begin
        if (mod_done) begin
          state_d = ST_IDX;
        end
      end
      ST_IDX: state_d = ST_RD0;
      ST_RD0: begin
        ram_re    = 1'b1;
        ram_raddr = idx0_q;
        state_d   = ST_RD1;
      end
      ST_RD1: begin
        ram_re    = 1'b1;
        ram_raddr = idx1_q;
        state_d   = ST_RD2;
      end
      ST_RD2: state_d = ST_IL;
      ST_IL: begin
        mul_a   = MA_W'(diff_l);
        mul_b   = {1'b0, frac};
        state_d = ST_IR;
      end
      ST_IR: begin
        mul_a   = MA_W'(diff_r);
        mul_b   = {1'b0, frac};
        state_d = ST_GL;
      end
      ST_GL: begin
        mul_a   = MA_W'(sl_q);
        mul_b   = {1'b0, gain_q};
        state_d = ST_GR;
      end
      ST_GR: begin
        mul_a   = MA_W'(sr_q);
        mul_b   = {1'b0, gain_q};
        state_d = ST_RCAP;
      end
      ST_RCAP, ST_STEPM: begin
        mul_a   = {1'b0, step_q};
        mul_b   = {1'b0, pitch_q};
        state_d = ST_POS;
      end
      ST_POS: state_d = ST_FINISH;
      ST_FINISH: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Voice control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q    <= '0;
      step_q   <= '0;
      active_q <= 1'b0;
    end else begin
      if (state_q == ST_START) begin
        pos_q    <= POS_W'(spos_q);
        step_q   <= sstep_q;
        active_q <= 1'b1;
      end
      if (state_q == ST_CHECK && one_shot_end) begin
        active_q <= 1'b0;  // one-shot ran out: hold the position
      end
      if (state_q == ST_POS) begin
        pos_q <= pos_adv;
      end
    end
  end

  // Datapath registers, loaded by the sequencer state
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      res_l_q <= '0;
      res_r_q <= '0;
    end
    unique case (state_q)
      ST_TICK:  len_q <= len_c;
      ST_CHECK: fwd_direct_q <= fwd_direct_c;
      ST_IDX: begin
        idx0_q <= r0[AW-1:0];
        idx1_q <= r1[AW-1:0];
      end
      ST_RD1: begin
        al_q <= ram_rdata[SAMPLE_BITS-1:0];
        ar_q <= ram_rdata[RAM_W-1:SAMPLE_BITS];
      end
      ST_RD2: begin
        bl_q <= ram_rdata[SAMPLE_BITS-1:0];
        br_q <= ram_rdata[RAM_W-1:SAMPLE_BITS];
      end
      ST_IR:   sl_q    <= interp_val;
      ST_GL:   sr_q    <= interp_val;
      ST_GR:   res_l_q <= gain_sat;
      ST_RCAP: res_r_q <= gain_sat;
      default: ;
    endcase
  end

  // Result register: load when the previous result is gone or leaves now
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (state_q == ST_FINISH && out_free) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_FINISH && out_free) begin
      out_l_q   <= res_l_q;
      out_r_q   <= res_r_q;
      out_act_q <= active_q;
    end
  end

  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {7'b0, out_act_q, out_r_q, out_l_q};

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  // The remainder unit only finishes while the sequencer waits for it
  a_mod_done_in_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mod_done |-> state_q == ST_MOD)
    else $error("remainder done outside of the wait state");

  // Only a start command arms the voice
  a_active_rise: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(active_q) |-> $past(state_q) == ST_START)
    else $error("voice armed without a start command");

  // The position moves only on start or at the end of a tick
  a_pos_update: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$stable(pos_q) |-> ($past(state_q) == ST_START || $past(state_q) == ST_POS))
    else $error("position changed outside of start or advance");

  // Leaving the finish state always presents a result
  a_finish_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FINISH && out_free) |=> m_axis_tvalid && state_q == ST_IDLE)
    else $error("finished command produced no result");

endmodule

// ----- rtl/core/lsp_ram.sv -----
// ----------------------------------------------------------------------------
// lsp_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module lsp_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

// ----- rtl/core/lsp_mod_unit.sv -----
// ----------------------------------------------------------------------------
// lsp_mod_unit
// Serial remainder unit: one restoring step per cycle over the dividend bits.
// ----------------------------------------------------------------------------
module lsp_mod_unit
  import lsp_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [INT_W-1:0] dividend_i,
  input  logic [LEN_W-1:0] divisor_i,
  output logic             done_o,
  output logic [LEN_W-1:0] rem_o
);

  localparam int CNT_W = $clog2(INT_W + 1);

  logic             busy_q;
  logic             done_q;
  logic [CNT_W-1:0] cnt_q;
  logic [INT_W-1:0] dvd_q;
  logic [LEN_W-1:0] div_q;
  logic [LEN_W-1:0] rem_q;

  logic [LEN_W:0] trial;
  logic [LEN_W:0] trial_sub;

  // Shift in the next dividend bit, subtract when it fits
  always_comb begin
    trial     = {rem_q, dvd_q[INT_W-1]};
    trial_sub = trial - {1'b0, div_q};
    if (trial >= {1'b0, div_q}) begin
      trial = trial_sub;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= CNT_W'(INT_W);
    end else if (busy_q) begin
      cnt_q <= cnt_q - 1'b1;
      if (cnt_q == CNT_W'(1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvd_q <= dividend_i;
      div_q <= divisor_i;
      rem_q <= '0;
    end else if (busy_q) begin
      dvd_q <= {dvd_q[INT_W-2:0], 1'b0};
      rem_q <= trial[LEN_W-1:0];
    end
  end

  assign done_o = done_q;
  assign rem_o  = rem_q;

endmodule

// ----- dv/testbench.sv -----
// ----------------------------------------------------------------------------
// looping_sample_player testbench
// Drives write, start, tick and unused commands through the command stream
// and checks every result frame against a predictor kept inside the bench.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import lsp_pkg::*;

  localparam int          SAMPLE_DEPTH = 65536;
  localparam int          CLK_HALF     = 10;
  localparam int          RESET_CYCLES = 12;
  localparam int          RANDOM_ITEMS = 1950;
  localparam int          DRAIN_CYCLES = 64;     // room for any stray result after the drain
  localparam int unsigned CYCLE_LIMIT  = 2_000_000;
  localparam int          MAX_REPORTS  = 40;
  localparam int          CMD_Q_DEPTH  = 4;

  // tuser code outside the command set; the block must ignore it
  localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;

  localparam int     STEP_MAX   = 1 << (STEP_W - 1);
  localparam int     PITCH_ONE  = 1 << PITCH_SHIFT;
  localparam int     GAIN_ONE   = 1 << GAIN_SHIFT;
  localparam longint FRAC_HALF  = longint'(1) << (FRAC_BITS - 1);
  localparam longint GAIN_HALF  = longint'(1) << (GAIN_SHIFT - 1);
  localparam longint SAMPLE_MAX = (longint'(1) << (SAMPLE_BITS - 1)) - 1;
  localparam longint SAMPLE_MIN = -SAMPLE_MAX - 1;

  // One command as it travels on the input stream
  typedef struct packed {
    logic [FUNC_W-1:0]             func;
    logic [15:0]                   addr;
    logic signed [SAMPLE_BITS-1:0] left;
    logic signed [SAMPLE_BITS-1:0] right;
    logic [INT_W-1:0]              pos;
    logic [STEP_W-1:0]             step;
    logic [PITCH_W-1:0]            pitch;
    logic [GAIN_W-1:0]             gain;
  } cmd_t;

  // One stereo output frame
  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] left;
    logic signed [SAMPLE_BITS-1:0] right;
    logic                          active;
  } frame_t;

  typedef struct packed {
    cmd_t   cmd;
    frame_t frame;
  } cmd_item_t;

  // --------------------------------------------------------------------------
  // DUT signals
  // --------------------------------------------------------------------------
  logic                 clk_i;
  logic                 rst_ni   = 1'b0;
  logic                 cfg_we   = 1'b0;
  cfg_idx_e             cfg_idx  = CFG_LOOP_EN;
  logic [LEN_W-1:0]     cfg_data = '0;
  logic                 s_tvalid = 1'b0;
  logic                 s_axis_tready;
  // sample_addr, left_in, right_in, start_pos, start_step, pitch_mod, gain,
  // one pad bit (lowest first)
  logic [135:0]         s_tdata  = '0;
  // func
  logic [FUNC_W-1:0]    s_tuser  = '0;
  logic                 m_axis_tvalid;
  logic                 m_tready = 1'b0;
  // left_out, right_out, voice_active, pad (lowest first)
  logic [39:0]          m_axis_tdata;

  looping_sample_player u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we),
    .cfg_idx_i     (cfg_idx),
    .cfg_data_i    (cfg_data),
    .s_axis_tvalid (s_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_tdata),
    .s_axis_tuser  (s_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  initial begin
    clk_i = 1'b0;
    forever #CLK_HALF clk_i = ~clk_i;
  end

  // --------------------------------------------------------------------------
  // Predictor state: sample store, voice and register copies
  // --------------------------------------------------------------------------
  logic signed [SAMPLE_BITS-1:0] left_mem  [SAMPLE_DEPTH];
  logic signed [SAMPLE_BITS-1:0] right_mem [SAMPLE_DEPTH];
  bit                            written   [SAMPLE_DEPTH];
  logic [POS_W-1:0]              play_pos  = '0;
  logic [STEP_W-1:0]             play_step = '0;
  logic                          voice_on  = 1'b0;

  logic             cfg_loop    = 1'b1;
  logic             cfg_rev     = 1'b0;
  logic [LEN_W-1:0] cfg_range   = '0;
  logic [OFF_W-1:0] cfg_off     = '0;
  logic [LEN_W-1:0] cfg_looplen = '0;

  // Commands waiting for the source, frames waiting for the result stream
  cmd_item_t   cmd_q[$];
  frame_t      frame_q[$];
  int unsigned outstanding = 0;   // commands queued whose frame is not yet checked
  int unsigned n_errors    = 0;
  bit          src_gaps    = 1'b0;
  bit          sink_stalls = 1'b0;

  // Effective length of the playable span for the current registers
  function automatic longint unsigned loop_span();
    if (!cfg_loop) return cfg_range;
    if (cfg_off >= cfg_range) return 0;
    if (cfg_looplen < cfg_range - cfg_off) return cfg_looplen;
    return cfg_range - cfg_off;
  endfunction

  // Map an integer position to a store row; span is never zero here
  function automatic logic [15:0] voice_index(input longint unsigned u,
                                              input longint unsigned span);
    longint r;
    if (cfg_rev) begin
      // read back from the range end; the loop offset plays no part
      r = longint'(cfg_range) - 1 - longint'((u > span) ? u % span : u);
      if (r < 0) r = 0;
    end else if (u < cfg_off) begin
      r = longint'(u);
    end else begin
      r = longint'((u - cfg_off) % span + cfg_off);
    end
    return r[15:0];
  endfunction

  // Tell whether a tick now would read the store, and which two rows
  function automatic bit tick_reads(output logic [15:0] ia, output logic [15:0] ib);
    longint unsigned whole, span;
    ia    = '0;
    ib    = '0;
    whole = play_pos[POS_W-1:FRAC_BITS];
    span  = loop_span();
    if (!voice_on || span == 0 || (!cfg_loop && whole + 2 > span)) return 1'b0;
    ia = voice_index(whole, span);
    ib = voice_index(whole + 1, span);
    return 1'b1;
  endfunction

  // Interpolate between two samples by the fraction, round, then apply gain
  function automatic logic signed [SAMPLE_BITS-1:0] blend_sample(
      input logic signed [SAMPLE_BITS-1:0] a, input logic signed [SAMPLE_BITS-1:0] b,
      input logic [FRAC_BITS-1:0] frac, input logic [GAIN_W-1:0] gain);
    longint acc, s, y;
    acc = longint'(a) * (longint'(1) << FRAC_BITS) + (longint'(b) - longint'(a)) * longint'(frac);
    s   = (acc + FRAC_HALF) >>> FRAC_BITS;
    y   = (s * longint'(gain) + GAIN_HALF) >>> GAIN_SHIFT;
    if (y > SAMPLE_MAX) y = SAMPLE_MAX;
    else if (y < SAMPLE_MIN) y = SAMPLE_MIN;
    return y[SAMPLE_BITS-1:0];
  endfunction

  // Apply one command to the predictor and return the frame it produces
  function automatic frame_t next_frame(input cmd_t c);
    frame_t          f;
    logic [15:0]     ia, ib;
    longint unsigned whole;
    f.left  = '0;
    f.right = '0;
    case (c.func)
      FUNC_WRITE: begin
        left_mem[c.addr]  = c.left;
        right_mem[c.addr] = c.right;
        written[c.addr]   = 1'b1;
      end
      FUNC_START: begin
        play_pos  = POS_W'(c.pos);
        play_step = c.step;
        voice_on  = 1'b1;
      end
      FUNC_TICK: begin
        if (voice_on) begin
          whole = play_pos[POS_W-1:FRAC_BITS];
          if (tick_reads(ia, ib)) begin
            f.left  = blend_sample(left_mem[ia], left_mem[ib], play_pos[FRAC_BITS-1:0],
                                   c.gain);
            f.right = blend_sample(right_mem[ia], right_mem[ib], play_pos[FRAC_BITS-1:0],
                                   c.gain);
          end
          // one-shot end: go silent and freeze the position
          if (!cfg_loop && whole + 2 > loop_span()) voice_on = 1'b0;
          else play_pos = play_pos + ((POS_W'(play_step) * POS_W'(c.pitch)) >> PITCH_SHIFT);
        end
      end
      default: ;
    endcase
    f.active = voice_on;
    return f;
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  function automatic cmd_t random_cmd(input logic [FUNC_W-1:0] func);
    cmd_t c;
    c.func  = func;
    c.addr  = $urandom;
    c.left  = $urandom;
    c.right = $urandom;
    c.pos   = $urandom;
    c.step  = $urandom_range(0, STEP_MAX);
    c.pitch = $urandom;
    c.gain  = $urandom_range(0, GAIN_ONE);
    return c;
  endfunction

  // Predict, then hand the command to the source; hold while the queue is full
  task automatic queue_item(input cmd_t c);
    cmd_item_t it;
    while (cmd_q.size() >= CMD_Q_DEPTH) @(posedge clk_i);
    it.cmd   = c;
    it.frame = next_frame(c);
    cmd_q.push_back(it);
    outstanding++;
  endtask

  // Send one command; a tick first gets writes for any row it would read
  // that was never written, so the store is never read undefined
  task automatic issue(input cmd_t c);
    cmd_t        fill;
    logic [15:0] ia, ib;
    if (c.func == FUNC_TICK && tick_reads(ia, ib)) begin
      if (!written[ia]) begin
        fill      = random_cmd(FUNC_WRITE);
        fill.addr = ia;
        queue_item(fill);
      end
      if (!written[ib]) begin
        fill      = random_cmd(FUNC_WRITE);
        fill.addr = ib;
        queue_item(fill);
      end
    end
    queue_item(c);
  endtask

  task automatic do_write(input logic [15:0] addr, input logic signed [15:0] l,
                          input logic signed [15:0] r);
    cmd_t c;
    c       = random_cmd(FUNC_WRITE);
    c.addr  = addr;
    c.left  = l;
    c.right = r;
    issue(c);
  endtask

  task automatic do_start(input logic [INT_W-1:0] pos, input logic [STEP_W-1:0] step);
    cmd_t c;
    c      = random_cmd(FUNC_START);
    c.pos  = pos;
    c.step = step;
    issue(c);
  endtask

  task automatic do_tick(input logic [PITCH_W-1:0] pitch, input logic [GAIN_W-1:0] gain);
    cmd_t c;
    c       = random_cmd(FUNC_TICK);
    c.pitch = pitch;
    c.gain  = gain;
    issue(c);
  endtask

  // Start a note: mostly near the playable range, sometimes anywhere
  task automatic random_start();
    logic [INT_W-1:0]  pos;
    logic [STEP_W-1:0] step;
    if ($urandom_range(0, 3) == 0) pos = $urandom;
    else pos = {16'($urandom_range(0, int'(cfg_range) + 3)), 16'($urandom)};
    case ($urandom_range(0, 9))
      0:       step = STEP_MAX;
      1:       step = '0;
      2, 3:    step = $urandom_range(0, STEP_MAX);
      default: step = $urandom_range(0, 4 * (1 << FRAC_BITS));
    endcase
    do_start(pos, step);
  endtask

  // Block until every queued command has returned its frame
  task automatic wait_idle();
    while (outstanding != 0) @(posedge clk_i);
  endtask

  // Write all five registers on consecutive cycles; only while idle
  task automatic set_config(input logic loop_on, input logic rev_on,
                            input logic [LEN_W-1:0] range_len,
                            input logic [OFF_W-1:0] loop_off,
                            input logic [LEN_W-1:0] loop_len);
    cfg_idx_e         which [5];
    logic [LEN_W-1:0] value [5];
    which = '{CFG_LOOP_EN, CFG_REVERSED, CFG_RANGE_LEN, CFG_LOOP_OFF, CFG_LOOP_LEN};
    value = '{LEN_W'(loop_on), LEN_W'(rev_on), range_len, LEN_W'(loop_off), loop_len};
    foreach (which[i]) begin
      cfg_we   <= 1'b1;
      cfg_idx  <= which[i];
      cfg_data <= value[i];
      @(posedge clk_i);
    end
    cfg_we      <= 1'b0;
    cfg_loop    = loop_on;
    cfg_rev     = rev_on;
    cfg_range   = range_len;
    cfg_off     = loop_off;
    cfg_looplen = loop_len;
  endtask

  // --------------------------------------------------------------------------
  // Source: pop commands and present them in bursts, with random gaps while src_gaps is set.
  // valid only drops once the current transaction has been taken.
  // --------------------------------------------------------------------------
  initial begin : source_proc
    cmd_item_t   cur;
    int unsigned burst_left;
    int unsigned gap_left;
    burst_left = 0;
    gap_left   = 0;
    forever begin
      @(posedge clk_i);
      if (s_tvalid && s_axis_tready) frame_q.push_back(cur.frame);
      if (!s_tvalid || s_axis_tready) begin
        if (gap_left != 0) begin
          gap_left--;
          s_tvalid <= 1'b0;
        end else if (cmd_q.size() != 0) begin
          cur      = cmd_q.pop_front();
          s_tdata  <= {1'b0, cur.cmd.gain, cur.cmd.pitch, cur.cmd.step, cur.cmd.pos,
                       cur.cmd.right, cur.cmd.left, cur.cmd.addr};
          s_tuser  <= cur.cmd.func;
          s_tvalid <= 1'b1;
          if (burst_left != 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(0, 12);
            if (src_gaps) gap_left = $urandom_range(1, 8);
          end
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Sink: check each result transaction against the oldest predicted frame,
  // and, while sink_stalls is set, toggle tready in alternating ready and stall runs.
  // --------------------------------------------------------------------------
  task automatic compare_field(input string what, input longint want, input longint got);
    if (want != got) begin
      if (n_errors < MAX_REPORTS)
        $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
      n_errors++;
    end
  endtask

  int unsigned run_left = 0;

  always @(posedge clk_i) begin : sink_proc
    frame_t want;
    if (m_axis_tvalid && m_tready) begin
      if (frame_q.size() == 0) begin
        if (n_errors < MAX_REPORTS)
          $display("%0t ns: result with nothing expected, expected none, actual %h",
                   $time, m_axis_tdata);
        n_errors++;
      end else begin
        want = frame_q.pop_front();
        compare_field("left_out", want.left, $signed(m_axis_tdata[15:0]));
        compare_field("right_out", want.right, $signed(m_axis_tdata[31:16]));
        compare_field("voice_active", want.active, m_axis_tdata[32]);
        outstanding--;
      end
    end
    if (run_left != 0) begin
      run_left--;
    end else if (!sink_stalls || !m_tready) begin
      m_tready <= 1'b1;
      run_left = $urandom_range(1, 12);
    end else begin
      m_tready <= 1'b0;
      run_left = $urandom_range(0, 6);
    end
  end

  // Watchdog: a stuck handshake ends the run here
  initial begin : watchdog
    int unsigned cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("looping_sample_player test failed");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Reset registers: looping on with a zero range, so the loop is empty
  task automatic test_power_up();
    do_tick(16'(PITCH_ONE), 16'(GAIN_ONE));         // tick with no voice
    issue(random_cmd(FUNC_UNUSED));                 // ignored while idle
    do_write(16'h0000, 16'sh7FFF, -16'sh8000);
    do_write(16'hFFFF, -16'sh8000, 16'sh7FFF);
    do_start(32'h0000_0000, STEP_W'(1 << FRAC_BITS));
    do_tick(16'(PITCH_ONE), 16'(GAIN_ONE));         // empty loop: silent, stays active
    issue(random_cmd(FUNC_UNUSED));                 // ignored while active
  endtask

  // Play once through a short range until the voice stops, then an empty range
  task automatic test_one_shot();
    wait_idle();
    set_config(1'b0, 1'b0, 17'd4, 16'd0, 17'd0);
    do_write(16'd1, 16'sh1234, -16'sh0FFF);
    do_write(16'd2, -16'sh7000, 16'sh6000);
    do_start(32'h0000_8000, STEP_W'(1 << FRAC_BITS));
    repeat (4) do_tick(16'(PITCH_ONE), 16'(GAIN_ONE));  // last one hits the end
    do_tick(16'(PITCH_ONE), 16'(GAIN_ONE));             // voice already off
    wait_idle();
    set_config(1'b0, 1'b0, 17'd0, 16'd0, 17'd0);
    do_start(32'h0000_0000, STEP_W'(1 << FRAC_BITS));
    do_tick(16'(PITCH_ONE), 16'(GAIN_ONE));             // zero length stops at once
  endtask

  // Reverse read, including the index past the range start that clamps to 0
  task automatic test_reverse();
    wait_idle();
    src_gaps    = 1'b1;
    sink_stalls = 1'b1;
    set_config(1'b1, 1'b1, 17'd6, 16'd0, 17'd6);
    do_start({16'd5, 16'h4000}, STEP_W'(3 << (FRAC_BITS - 1)));
    do_tick(16'(PITCH_ONE), 16'(GAIN_ONE));
    do_tick(16'(PITCH_ONE), 16'd0);
    do_tick(16'(PITCH_ONE), 16'(GAIN_ONE / 2));
  endtask

  // Widest range, largest offset and loop, largest step and pitch
  task automatic test_extremes();
    wait_idle();
    set_config(1'b1, 1'b0, 17'd65536, 16'hFFFF, 17'd65536);
    do_write(16'hFFFF, 16'sh7FFF, -16'sh8000);
    do_start(32'hFFFF_FFFF, STEP_W'(STEP_MAX));
    do_tick(16'hFFFF, 16'(GAIN_ONE));
    do_tick(16'h0000, 16'(GAIN_ONE));                // zero pitch holds the position
    wait_idle();
    set_config(1'b1, 1'b0, 17'd65536, 16'd0, 17'd65536);
    do_start(32'hFFFE_8000, STEP_W'(1 << FRAC_BITS));
    repeat (2) do_tick(16'(PITCH_ONE), 16'(GAIN_ONE));
  endtask

  // Random register sets, each followed by notes of random ticks with noise
  task automatic test_random_play();
    int unsigned      n_done;
    logic             loop_on, rev_on;
    logic [LEN_W-1:0] range_len, loop_len;
    logic [OFF_W-1:0] loop_off;
    logic [PITCH_W-1:0] pitch;
    logic [GAIN_W-1:0]  gain;
    n_done = 0;
    while (n_done < RANDOM_ITEMS) begin
      wait_idle();
      loop_on = $urandom_range(0, 1);
      rev_on  = $urandom_range(0, 1);
      case ($urandom_range(0, 7))
        0:       range_len = '0;
        1:       range_len = 17'd65536;
        2:       range_len = $urandom_range(1, 65536);
        default: range_len = $urandom_range(1, 48);
      endcase
      case ($urandom_range(0, 5))
        0:       loop_off = 16'hFFFF;
        1:       loop_off = $urandom;
        default: loop_off = (range_len > 65535) ? 16'($urandom) :
                                                  16'($urandom_range(0, int'(range_len)));
      endcase
      case ($urandom_range(0, 5))
        0:       loop_len = '0;
        1:       loop_len = 17'd65536;
        2:       loop_len = $urandom_range(0, 65536);
        default: loop_len = $urandom_range(1, (range_len == 0) ? 1 : int'(range_len));
      endcase
      set_config(loop_on, rev_on, range_len, loop_off, loop_len);
      // some phases run with no idling on either side
      src_gaps    = ($urandom_range(0, 3) != 0);
      sink_stalls = ($urandom_range(0, 3) != 0);

      repeat ($urandom_range(0, 6)) begin
        issue(random_cmd(FUNC_WRITE));
        n_done++;
      end
      repeat ($urandom_range(1, 4)) begin
        random_start();
        n_done++;
        repeat ($urandom_range(4, 40)) begin
          case ($urandom_range(0, 19))
            0: issue(random_cmd(FUNC_UNUSED));      // ignored, not counted
            1: begin
              issue(random_cmd(FUNC_WRITE));
              n_done++;
            end
            2: begin
              random_start();                       // retrigger mid-note
              n_done++;
            end
            default: begin
              if ($urandom_range(0, 4) < 3)
                pitch = $urandom_range(PITCH_ONE / 2, 2 * PITCH_ONE);
              else
                pitch = $urandom;
              case ($urandom_range(0, 9))
                0:       gain = GAIN_ONE;
                1:       gain = '0;
                default: gain = $urandom_range(0, GAIN_ONE);
              endcase
              do_tick(pitch, gain);
              n_done++;
            end
          endcase
        end
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_power_up();
    test_one_shot();
    test_reverse();
    test_extremes();
    test_random_play();

    // drain, then leave room for any stray result
    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (n_errors == 0) begin
      $display("looping_sample_player test passed");
    end else begin
      $display("looping_sample_player test failed");
    end
    $finish;
  end

endmodule
